// ===== hdl/wmoe_pkg.sv =====
// Shared types and constants for the word matcher with one extra letter.
`default_nettype none
package wmoe_pkg;

  // Sizing
  localparam int MAX_TARGET = 32;
  localparam int LINE_CHARS = 256;
  localparam int CH_W       = 8;
  localparam int POS_W      = $clog2(LINE_CHARS);
  localparam int LEN_W      = 6;
  localparam int TIDX_W     = $clog2(MAX_TARGET);
  localparam int TGT_W      = MAX_TARGET * CH_W;

  // Config bus
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TGT_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TGT_SECOND = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TGT_THIRD  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TGT_HIGH   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TGT_LENGTH = 3'd4;

  // Character codes
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;

  // Target setup seen by the matcher
  typedef struct packed {
    logic [TGT_W-1:0] chars;
    logic [LEN_W-1:0] length;
  } wmoe_cfg_t;

  // One reported word
  typedef struct packed {
    logic [POS_W-1:0] word_start;
    logic [LEN_W-1:0] word_length;
    logic             extra_letter;
  } wmoe_result_t;

endpackage
`default_nettype wire

// ===== hdl/wmoe_ifs.sv =====
// Valid/ready channel interfaces for characters in and matches out.
`default_nettype none
interface wmoe_char_if;
  logic                       valid;
  logic                       ready;
  logic [wmoe_pkg::CH_W-1:0]  ch;
  logic                       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

interface wmoe_match_if;
  logic                        valid;
  logic                        ready;
  logic [wmoe_pkg::POS_W-1:0]  word_start;
  logic [wmoe_pkg::LEN_W-1:0]  word_length;
  logic                        extra_letter;

  modport source (output valid, output word_start, output word_length,
                  output extra_letter, input ready);
  modport sink   (input valid, input word_start, input word_length,
                  input extra_letter, output ready);
endinterface
`default_nettype wire

// ===== hdl/wmoe_cfg.sv =====
// APB register file holding the target word and its length.
`default_nettype none
module wmoe_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wmoe_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wmoe_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wmoe_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output wmoe_pkg::wmoe_cfg_t                  cfg
);
  import wmoe_pkg::*;

  logic [63:0]           tgt_low;
  logic [63:0]           tgt_second;
  logic [63:0]           tgt_third;
  logic [63:0]           tgt_high;
  logic [LEN_W-1:0]      tgt_length;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_low    <= '0;
      tgt_second <= '0;
      tgt_third  <= '0;
      tgt_high   <= '0;
      tgt_length <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_TGT_LOW:    tgt_low    <= pwdata;
        REG_TGT_SECOND: tgt_second <= pwdata;
        REG_TGT_THIRD:  tgt_third  <= pwdata;
        REG_TGT_HIGH:   tgt_high   <= pwdata;
        REG_TGT_LENGTH: tgt_length <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_TGT_LOW:    prdata = tgt_low;
      REG_TGT_SECOND: prdata = tgt_second;
      REG_TGT_THIRD:  prdata = tgt_third;
      REG_TGT_HIGH:   prdata = tgt_high;
      REG_TGT_LENGTH: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, tgt_length};
      default:        prdata = '0;
    endcase
  end

  assign cfg.chars  = {tgt_high, tgt_third, tgt_second, tgt_low};
  assign cfg.length = tgt_length;

endmodule
`default_nettype wire

// ===== hdl/wmoe_core.sv =====
// Input register and per-character match update for the two match paths.
`default_nettype none
module wmoe_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wmoe_pkg::wmoe_cfg_t  cfg,
  wmoe_char_if.sink                 char_in,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output wmoe_pkg::wmoe_result_t    res
);
  import wmoe_pkg::*;

  // Input register
  logic             s1_valid;
  logic [CH_W-1:0]  s1_ch;
  logic             s1_eol;
  logic             s1_go;

  // Line and word state
  logic [POS_W-1:0] line_position, line_position_next;
  logic [POS_W-1:0] word_start, word_start_next;
  logic [LEN_W-1:0] word_count, word_count_next;
  logic             in_word, in_word_next;
  logic             exact_alive, exact_alive_next;
  logic             skip_alive, skip_alive_next;

  // Match datapath
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] k_m1;
  logic [CH_W-1:0]  tc_k, tc_km1;
  logic             is_delim, is_let;
  logic             new_exact, new_skip;
  logic [LEN_W-1:0] sat_count;
  logic [LEN_W-1:0] j_count;
  logic             j_in_word, j_exact, j_skip;
  logic             exact_hit, skip_hit, hit;

  assign char_in.ready = !s1_valid || s1_go;
  assign s1_go         = s1_valid && (!hit || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (char_in.ready) begin
      s1_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      s1_ch  <= char_in.ch;
      s1_eol <= char_in.end_of_line;
    end
  end

  // Target length, clamped to the buffer size
  assign len_eff = (cfg.length > LEN_W'(MAX_TARGET)) ? LEN_W'(MAX_TARGET) : cfg.length;
  assign k_m1    = word_count - LEN_W'(1);
  assign tc_k    = cfg.chars[{word_count[TIDX_W-1:0], 3'b000} +: CH_W];
  assign tc_km1  = cfg.chars[{k_m1[TIDX_W-1:0], 3'b000} +: CH_W];

  // Character class
  always_comb begin
    is_delim = (s1_ch == CH_SPACE) || (s1_ch == CH_NL) ||
               (s1_ch == CH_TAB) || (s1_ch == CH_NUL);
    is_let   = s1_ch inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
  end

  // Path updates for a word character
  always_comb begin
    new_exact = exact_alive && (word_count < len_eff) && is_let && (s1_ch == tc_k);
    new_skip  = (skip_alive && (word_count != '0) && (k_m1 < len_eff) && is_let &&
                 (s1_ch == tc_km1)) ||
                (exact_alive && (word_count <= len_eff));
    if ({1'b0, word_count} < ({1'b0, len_eff} + (LEN_W+1)'(2))) begin
      sat_count = word_count + LEN_W'(1);
    end else begin
      sat_count = word_count;
    end
  end

  // Word judgement: on the stored state at a delimiter, on the updated one otherwise
  always_comb begin
    if (is_delim) begin
      j_in_word = in_word;
      j_count   = word_count;
      j_exact   = exact_alive;
      j_skip    = skip_alive;
    end else begin
      j_in_word = 1'b1;
      j_count   = sat_count;
      j_exact   = new_exact;
      j_skip    = new_skip;
    end
    exact_hit = (j_count == len_eff) && j_exact;
    skip_hit  = (j_count == (len_eff + LEN_W'(1))) && j_skip;
    hit       = s1_valid && j_in_word && (is_delim || s1_eol) && (exact_hit || skip_hit);
  end

  assign res_valid        = hit;
  assign res.word_start   = word_start_next;
  assign res.word_length  = j_count;
  assign res.extra_letter = !exact_hit;

  // Next state
  always_comb begin
    word_start_next = word_start;
    if (is_delim) begin
      in_word_next     = 1'b0;
      word_count_next  = '0;
      exact_alive_next = 1'b1;
      skip_alive_next  = 1'b0;
    end else begin
      in_word_next     = 1'b1;
      word_count_next  = sat_count;
      exact_alive_next = new_exact;
      skip_alive_next  = new_skip;
      if (!in_word) begin
        word_start_next = line_position;
      end
    end
    if (s1_eol) begin
      in_word_next       = 1'b0;
      word_count_next    = '0;
      exact_alive_next   = 1'b1;
      skip_alive_next    = 1'b0;
      line_position_next = '0;
    end else if ({1'b0, line_position} + (POS_W+1)'(1) >= (POS_W+1)'(LINE_CHARS)) begin
      line_position_next = '0;
    end else begin
      line_position_next = line_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      word_start    <= '0;
      word_count    <= '0;
      in_word       <= 1'b0;
      exact_alive   <= 1'b1;
      skip_alive    <= 1'b0;
    end else if (s1_go) begin
      line_position <= line_position_next;
      word_start    <= word_start_next;
      word_count    <= word_count_next;
      in_word       <= in_word_next;
      exact_alive   <= exact_alive_next;
      skip_alive    <= skip_alive_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wmoe_outq.sv =====
// Two-entry result queue driving the match output channel.
`default_nettype none
module wmoe_outq (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   enq_valid,
  output logic                        enq_ready,
  input  wire wmoe_pkg::wmoe_result_t enq_data,
  wmoe_match_if.source                match_out
);
  import wmoe_pkg::*;

  wmoe_result_t mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;
  wmoe_result_t head;

  assign enq_ready = (count != 2'd2);
  assign push      = enq_valid && enq_ready;
  assign pop       = match_out.valid && match_out.ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= enq_data;
    end
  end

  assign head                   = mem[rd_ptr];
  assign match_out.valid        = (count != 2'd0);
  assign match_out.word_start   = head.word_start;
  assign match_out.word_length  = head.word_length;
  assign match_out.extra_letter = head.extra_letter;

endmodule
`default_nettype wire

// ===== hdl/word_match_one_extra_letter.sv =====
// Top level of the word matcher that accepts the target or the target plus one letter.
//
// Usage:
//   char_in takes one byte of a text line per beat (ch, end_of_line). Space,
//   tab, newline and zero bytes split words; end_of_line closes the line and
//   resets the position count. match_out gives one beat per matched word:
//   start position in the line, length, and whether one extra letter was
//   dropped to get the match.
//   The target word and its length are written over the APB port while no
//   characters are in flight; register i sits at byte address 8*i.
// Throughput and path:
//   One character per cycle sustained while match_out keeps up. A character is
//   held in the input register, where the match paths are updated, and its
//   result is registered in the result queue before it shows on match_out.
// Reset:
//   Synchronous rst clears the line position, the word state and the result
//   queue, and sets the target to length 1 with all-zero characters.
// Stall:
//   A two-entry result queue holds matches while match_out is stalled; input
//   keeps flowing until the queue is full and a new match is waiting.
`default_nettype none
module word_match_one_extra_letter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wmoe_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wmoe_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wmoe_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  wmoe_char_if.sink                            char_in,
  wmoe_match_if.source                         match_out
);
  import wmoe_pkg::*;

  wmoe_cfg_t    cfg;
  logic         res_valid;
  logic         res_ready;
  wmoe_result_t res;

  wmoe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wmoe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .char_in   (char_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  wmoe_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (res_valid),
    .enq_ready (res_ready),
    .enq_data  (res),
    .match_out (match_out)
  );

endmodule
`default_nettype wire

// ===== test/word_match_one_extra_letter_tb.sv =====
`timescale 1ns / 1ps
// Testbench for word_match_one_extra_letter: directed table, then random text lines, scoreboarded.
module word_match_one_extra_letter_tb;
  import wmoe_pkg::*;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    logic [1:0]       ph;
    logic [CH_W-1:0]  ch;
    logic             eol;
    logic             typed;
    logic             hit;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             extra;
  } dir_row_t;

  localparam int NUM_DIR     = 26;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_PRINTS  = 50;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  wmoe_char_if  char_bus ();
  wmoe_match_if match_bus ();

  word_match_one_extra_letter uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .char_in   (char_bus),
    .match_out (match_bus)
  );

  // Target as the matcher should hold it
  logic [63:0]      tgt_words [4];
  logic [LEN_W-1:0] tgt_len;
  logic [CH_W-1:0]  tgt_bytes [MAX_TARGET];

  // Word tracking state of the matcher model
  logic [POS_W-1:0] line_pos;
  logic [POS_W-1:0] word_begin;
  int               char_cnt;
  bit               in_word;
  bit               exact_ok;
  bit               skip_ok;

  wmoe_result_t pending_matches [$];
  int           errors;
  int           chars_sent;
  int           matches_seen;
  int           extra_seen;
  bit           calm;

  int phase_len [NUM_PHASES] = '{3, 1, 0, 32, 63, 5, 2, 40, 7, 4, 6, 33};

  // Directed table: reset target, then "cat", then length zero
  dir_row_t dir_rows [NUM_DIR] = '{
    '{0, "a",      0, 1, 0, 0, 0, 0},
    '{0, CH_SPACE, 0, 1, 0, 0, 0, 0},
    '{0, 8'hFF,    1, 1, 0, 0, 0, 0},
    '{1, "c",      0, 0, 0, 0, 0, 0},
    '{1, "a",      0, 0, 0, 0, 0, 0},
    '{1, "t",      0, 0, 0, 0, 0, 0},
    '{1, CH_SPACE, 0, 1, 1, 0, 3, 0},
    '{1, "c",      0, 0, 0, 0, 0, 0},
    '{1, "a",      0, 0, 0, 0, 0, 0},
    '{1, "r",      0, 0, 0, 0, 0, 0},
    '{1, "t",      0, 0, 0, 0, 0, 0},
    '{1, CH_TAB,   0, 1, 1, 4, 4, 1},
    '{1, "1",      0, 0, 0, 0, 0, 0},
    '{1, "c",      0, 0, 0, 0, 0, 0},
    '{1, "a",      0, 0, 0, 0, 0, 0},
    '{1, "t",      1, 1, 1, 9, 4, 1},
    '{1, "c",      0, 0, 0, 0, 0, 0},
    '{1, "a",      0, 0, 0, 0, 0, 0},
    '{1, "t",      0, 0, 0, 0, 0, 0},
    '{1, CH_NL,    1, 1, 1, 0, 3, 0},
    '{1, CH_NUL,   0, 1, 0, 0, 0, 0},
    '{1, "c",      0, 0, 0, 0, 0, 0},
    '{1, "a",      0, 0, 0, 0, 0, 0},
    '{1, 8'h80,    1, 0, 0, 0, 0, 0},
    '{2, "z",      0, 0, 0, 0, 0, 0},
    '{2, CH_SPACE, 1, 1, 1, 0, 1, 1}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int eff_len();
    return (int'(tgt_len) > MAX_TARGET) ? MAX_TARGET : int'(tgt_len);
  endfunction

  function automatic logic [CH_W-1:0] tgt_char(int k);
    return tgt_words[(k >> 3) & 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic bit is_delim(logic [CH_W-1:0] c);
    return c == CH_SPACE || c == CH_NL || c == CH_TAB || c == CH_NUL;
  endfunction

  function automatic void clear_word();
    in_word  = 1'b0;
    char_cnt = 0;
    exact_ok = 1'b1;
    skip_ok  = 1'b0;
  endfunction

  // Judge the open word at its end; 1 when it matches
  function automatic bit close_word(output wmoe_result_t m);
    int len;
    bit hit;
    len = eff_len();
    hit = 1'b0;
    m   = '0;
    if (in_word) begin
      if (char_cnt == len && exact_ok) begin
        hit = 1'b1;
        m.extra_letter = 1'b0;
      end else if (char_cnt == len + 1 && skip_ok) begin
        hit = 1'b1;
        m.extra_letter = 1'b1;
      end
      if (hit) begin
        m.word_start  = word_begin;
        m.word_length = LEN_W'(char_cnt);
      end
    end
    clear_word();
    return hit;
  endfunction

  // Advance the matcher by one character; 1 when a match comes out
  function automatic bit word_step(logic [CH_W-1:0] c, bit e, output wmoe_result_t m);
    int               len;
    int               k;
    bit               letter;
    bit               nx;
    bit               ns;
    bit               hit;
    logic [POS_W-1:0] pos;
    len = eff_len();
    pos = line_pos;
    hit = 1'b0;
    m   = '0;
    if (is_delim(c)) begin
      hit = close_word(m);
    end else begin
      k      = char_cnt;
      letter = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
      if (!in_word) begin
        in_word    = 1'b1;
        word_begin = pos;
      end
      nx = exact_ok && k < len && letter && c == tgt_char(k);
      ns = (skip_ok && k >= 1 && k - 1 < len && letter && c == tgt_char(k - 1)) ||
           (exact_ok && k <= len);
      exact_ok = nx;
      skip_ok  = ns;
      if (k < len + 2) char_cnt = k + 1;
      if (e) hit = close_word(m);
    end
    if (e) begin
      line_pos = '0;
      clear_word();
    end else begin
      line_pos = (int'(pos) + 1 >= LINE_CHARS) ? '0 : pos + 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [CH_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_LC_A + CH_W'($urandom_range(0, 25));
    return CH_UC_A + CH_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CH_W-1:0] rand_nondelim();
    logic [CH_W-1:0] c;
    do c = CH_W'($urandom_range(0, 255)); while (is_delim(c));
    return c;
  endfunction

  function automatic logic [CH_W-1:0] rand_delim();
    case ($urandom_range(0, 7))
      0: return CH_TAB;
      1: return CH_NL;
      2: return CH_NUL;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [63:0] target_word(int w);
    logic [63:0] v;
    for (int b = 0; b < 8; b++) v[b * 8 +: 8] = tgt_bytes[w * 8 + b];
    return v;
  endfunction

  function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (errors < MAX_PRINTS)
      $display("MISMATCH %s at %0t: expected %0d, got %0d", what, $time, want, got);
    errors++;
  endfunction

  // Register write: setup phase, access phase, then the bus returns to idle
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 3'b000});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_TGT_LENGTH) tgt_len = v[LEN_W-1:0];
    else if (idx <= REG_TGT_HIGH) tgt_words[idx] = v;
    @(posedge clk);
  endtask

  task automatic load_target(int n);
    apb_write(REG_TGT_LOW,    target_word(0));
    apb_write(REG_TGT_SECOND, target_word(1));
    apb_write(REG_TGT_THIRD,  target_word(2));
    apb_write(REG_TGT_HIGH,   target_word(3));
    apb_write(REG_TGT_LENGTH, 64'(n));
  endtask

  // Stop feeding, wait out every pending match, then idle for the number of clocks given
  task automatic settle(int n);
    char_bus.valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (n) @(posedge clk);
  endtask

  // Present one character and wait for its beat
  task automatic send_char(logic [CH_W-1:0] c, bit e, output bit hit, output wmoe_result_t m);
    if (!calm && $urandom_range(0, 4) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    char_bus.valid       <= 1'b1;
    char_bus.ch          <= c;
    char_bus.end_of_line <= e;
    do @(posedge clk); while (!char_bus.ready);
    hit = word_step(c, e, m);
    chars_sent++;
  endtask

  // Random lines built mostly from target-shaped words
  task automatic send_text(int quota, bit first_long);
    logic [CH_W-1:0] line [$];
    logic [CH_W-1:0] w [$];
    int              sent;
    int              goal;
    int              len;
    bit              hit;
    wmoe_result_t    m;
    sent = 0;
    len  = eff_len();
    while (sent < quota) begin
      line.delete();
      goal = ((first_long && sent == 0) || $urandom_range(0, 24) == 0) ?
             $urandom_range(260, 300) : $urandom_range(1, 60);
      while (line.size() < goal) begin
        if ($urandom_range(0, 3) == 0) line.push_back(rand_delim());
        w.delete();
        for (int i = 0; i < len; i++) w.push_back(tgt_bytes[i]);
        case ($urandom_range(0, 9))
          0, 1, 2: ;
          3, 4, 5: w.insert($urandom_range(0, len),
                            ($urandom_range(0, 2) == 0) ? rand_nondelim() : rand_letter());
          6: if (w.size() > 0) w[$urandom_range(0, w.size() - 1)] = rand_letter();
          7: if (w.size() > 0) w.delete($urandom_range(0, w.size() - 1));
          8: begin
            w.delete();
            repeat ($urandom_range(1, len + 2)) w.push_back(rand_letter());
          end
          default: begin
            w.delete();
            repeat ($urandom_range(1, 6)) w.push_back(rand_nondelim());
          end
        endcase
        if (w.size() == 0) w.push_back(rand_letter());
        foreach (w[i]) line.push_back(w[i]);
        line.push_back(rand_delim());
      end
      // line ends on a word character half the time
      if ($urandom_range(0, 1) == 0) void'(line.pop_back());
      // keep the phase on its quota, but let the opening long line run past the wrap
      if (!(first_long && sent == 0))
        while (line.size() > quota - sent) void'(line.pop_back());
      foreach (line[i]) begin
        send_char(line[i], i == line.size() - 1, hit, m);
        if (hit) pending_matches.push_back(m);
      end
      sent += line.size();
    end
  endtask

  // Result side: random stalls until the last phase
  initial begin
    match_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        match_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      match_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Compare each match beat with the oldest expectation
  always @(posedge clk) begin
    wmoe_result_t want;
    if (!rst && match_bus.valid && match_bus.ready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("match with none pending, word_start", 0, match_bus.word_start);
      end else begin
        want = pending_matches.pop_front();
        if (match_bus.word_start !== want.word_start)
          report_mismatch("word_start", want.word_start, match_bus.word_start);
        if (match_bus.word_length !== want.word_length)
          report_mismatch("word_length", want.word_length, match_bus.word_length);
        if (match_bus.extra_letter !== want.extra_letter)
          report_mismatch("extra_letter", want.extra_letter, match_bus.extra_letter);
        matches_seen++;
        if (want.extra_letter) extra_seen++;
      end
    end
  end

  // Main sequence
  initial begin
    bit           hit;
    wmoe_result_t m;
    int           cur_ph;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    char_bus.valid       <= 1'b0;
    char_bus.ch          <= '0;
    char_bus.end_of_line <= 1'b0;
    calm         = 1'b0;
    errors       = 0;
    chars_sent   = 0;
    matches_seen = 0;
    extra_seen   = 0;
    cur_ph       = 0;
    foreach (tgt_words[i]) tgt_words[i] = '0;
    tgt_len    = LEN_W'(1);
    line_pos   = '0;
    word_begin = '0;
    clear_word();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].ph) != cur_ph) begin
        settle(4);
        cur_ph = dir_rows[i].ph;
        if (cur_ph == 1) begin
          foreach (tgt_bytes[b]) tgt_bytes[b] = '0;
          tgt_bytes[0] = "c";
          tgt_bytes[1] = "a";
          tgt_bytes[2] = "t";
          load_target(3);
        end else begin
          apb_write(REG_TGT_LENGTH, 64'(0));
        end
      end
      send_char(dir_rows[i].ch, dir_rows[i].eol, hit, m);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].hit)
          pending_matches.push_back('{dir_rows[i].start, dir_rows[i].len, dir_rows[i].extra});
      end else if (hit) begin
        pending_matches.push_back(m);
      end
    end

    // Random phases, each with its own target
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle(4);
      foreach (tgt_bytes[b])
        tgt_bytes[b] = (b < phase_len[p]) ? rand_letter() : CH_W'($urandom_range(0, 255));
      if (p == 5 || p == 9)
        tgt_bytes[$urandom_range(0, 2)] = CH_W'($urandom_range(128, 255));
      if (p == NUM_PHASES - 1) calm = 1'b1;
      load_target(phase_len[p]);
      send_text(PHASE_ITEMS, p == 6);
    end

    settle(10);
    $display("Sent %0d characters under %0d target settings;",
             chars_sent, NUM_PHASES + 3);
    $display("checked %0d matches, %0d with an extra letter.", matches_seen, extra_seen);
    $display("Covered target lengths 0 to 63, all delimiters, line ends on words");
    $display("and on delimiters, and the line position wrap.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
